### rtl/bsrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsrt_pkg;

	// list depth and field widths
	localparam int MAX_RANGES = 16;
	localparam int NUM_W      = 16;
	localparam int CNT_W      = $clog2(MAX_RANGES + 1);
	localparam int ADDR_W     = $clog2(MAX_RANGES);

	// request transaction
	typedef struct packed {
		logic             has_number;
		logic [NUM_W-1:0] batch_number;
		logic             final_marker;
	} req_t;

	// response transaction
	typedef struct packed {
		logic             done_res;
		logic [NUM_W-1:0] contiguous_high;
		logic             overflow;
	} rsp_t;

	// one stored range, closed interval
	typedef struct packed {
		logic [NUM_W-1:0] lo;
		logic [NUM_W-1:0] hi;
	} entry_t;

	// classification of a number against one range
	typedef struct packed {
		logic covered;
		logic above_adj;
		logic below_adj;
		logic above;
	} cmp_t;

	// sequencer status toward the top level
	typedef struct packed {
		logic             idle;
		logic             res_valid;
		logic [CNT_W-1:0] count;
	} stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WALK,
		ST_CHK,
		ST_MRD,
		ST_MCHK,
		ST_INS,
		ST_INS_WR,
		ST_REM,
		ST_REM_WR,
		ST_FRD,
		ST_FCHK,
		ST_RES
	} state_t;

endpackage

`default_nettype wire

### rtl/batch_sequence_range_tracker.sv
// Batch sequence range tracker.
// Request channel (req_valid / req_ready / req) carries one batch report per
// transaction; response channel (rsp_valid / rsp_ready / rsp) returns exactly
// one result per request, in order.
// The block keeps the seen batch numbers as an ascending list of up to
// MAX_RANGES ranges in a small memory and walks it from the top entry down
// with one shared compare unit, one memory read per step.
// A report without a number goes straight to the result; otherwise the walk
// examines ranges from the top, moves entries one at a time when a range is
// inserted or removed, and then forms the result. One request is in work at a
// time; req_ready is low from acceptance until the sequencer has handed its
// result to the output register.
// The output register holds a finished response while the receiver stalls,
// and a new request may be accepted meanwhile; its result waits in the
// sequencer until the register frees up.
// Reset empties the list and clears the recorded total; memory contents are
// never used before being written, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module batch_sequence_range_tracker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire bsrt_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output bsrt_pkg::rsp_t      rsp
);

	bsrt_pkg::stat_t stat;
	bsrt_pkg::rsp_t  core_res;
	logic            start;
	logic            res_take;
	logic            rsp_valid_q;
	bsrt_pkg::rsp_t  rsp_q;

	assign req_ready = stat.idle;
	assign start     = req_valid && stat.idle;
	assign res_take  = stat.res_valid && (!rsp_valid_q || rsp_ready);

	bsrt_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.res_take (res_take),
		.stat     (stat),
		.res      (core_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= core_res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// one request in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while a transaction is still in work");

	// list never grows past its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= bsrt_pkg::CNT_W'(bsrt_pkg::MAX_RANGES))
		else $error("range count above list depth");

	// overflow only reported with a full list
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		stat.res_valid && core_res.overflow
			|-> stat.count == bsrt_pkg::CNT_W'(bsrt_pkg::MAX_RANGES))
		else $error("overflow reported with room in the list");

	// a contiguous high value means exactly one range
	a_single_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.res_valid && (core_res.contiguous_high != '0)
			|-> stat.count == bsrt_pkg::CNT_W'(1))
		else $error("contiguous high reported with more than one range");

endmodule

`default_nettype wire

### rtl/bsrt_cmp.sv
`timescale 1ns / 1ps
`default_nettype none

module bsrt_cmp (
	input  wire logic [bsrt_pkg::NUM_W-1:0] num,
	input  wire bsrt_pkg::entry_t           ent,
	output bsrt_pkg::cmp_t                  res
);

	logic [bsrt_pkg::NUM_W:0]   hi_inc;
	logic [bsrt_pkg::NUM_W-1:0] lo_dec;

	// edge neighbors, high side kept one bit wider so it never wraps
	assign hi_inc = {1'b0, ent.hi} + {{bsrt_pkg::NUM_W{1'b0}}, 1'b1};
	assign lo_dec = ent.lo - {{(bsrt_pkg::NUM_W-1){1'b0}}, 1'b1};

	// shared compare unit
	always_comb begin
		res.covered   = (num >= ent.lo) && (num <= ent.hi);
		res.above_adj = (hi_inc == {1'b0, num});
		res.below_adj = (ent.lo != '0) && (lo_dec == num);
		res.above     = (ent.hi < num);
	end

endmodule

`default_nettype wire

### rtl/bsrt_core.sv
`timescale 1ns / 1ps
`default_nettype none

module bsrt_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire bsrt_pkg::req_t  req,
	input  wire logic            res_take,
	output bsrt_pkg::stat_t      stat,
	output bsrt_pkg::rsp_t       res
);

	localparam int CW = bsrt_pkg::CNT_W;
	localparam int AW = bsrt_pkg::ADDR_W;
	localparam int NW = bsrt_pkg::NUM_W;

	bsrt_pkg::state_t state_q, state_d;

	bsrt_pkg::entry_t mem_q [bsrt_pkg::MAX_RANGES];
	bsrt_pkg::entry_t rd_q;
	bsrt_pkg::entry_t wdata;
	logic [AW-1:0]    waddr;
	logic [AW-1:0]    raddr;
	logic             we;

	logic [CW-1:0] count_q;
	logic [NW-1:0] final_q;
	logic [NW-1:0] n_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] p_q;
	logic [NW-1:0] cur_hi_q;
	logic          ovf_q;
	bsrt_pkg::rsp_t res_q;

	bsrt_pkg::cmp_t cmp;
	logic [CW-1:0]  i_dec;
	logic [CW-1:0]  k_dec;
	logic [CW-1:0]  k_inc;
	logic           full;
	logic [NW-1:0]  high;

	assign i_dec = i_q - CW'(1);
	assign k_dec = k_q - CW'(1);
	assign k_inc = k_q + CW'(1);
	assign full  = (count_q == CW'(bsrt_pkg::MAX_RANGES));
	assign high  = ((count_q == CW'(1)) && (rd_q.lo == NW'(1))) ? rd_q.hi : '0;

	// one compare unit, fed by whichever entry was just read
	bsrt_cmp u_cmp (
		.num (n_q),
		.ent (rd_q),
		.res (cmp)
	);

	// range memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsrt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory control
	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = '0;
		wdata   = '0;
		raddr   = '0;
		unique case (state_q)
			bsrt_pkg::ST_IDLE: begin
				if (start) begin
					state_d = req.has_number ? bsrt_pkg::ST_WALK : bsrt_pkg::ST_RES;
				end
			end
			bsrt_pkg::ST_WALK: begin
				if (i_q == '0) begin
					state_d = full ? bsrt_pkg::ST_FRD : bsrt_pkg::ST_INS;
				end else begin
					raddr   = i_dec[AW-1:0];
					state_d = bsrt_pkg::ST_CHK;
				end
			end
			bsrt_pkg::ST_CHK: begin
				if (cmp.covered) begin
					state_d = bsrt_pkg::ST_FRD;
				end else if (cmp.above_adj) begin
					we      = 1'b1;
					waddr   = i_q[AW-1:0];
					wdata   = '{lo: rd_q.lo, hi: n_q};
					state_d = bsrt_pkg::ST_FRD;
				end else if (cmp.below_adj) begin
					if (i_q != '0) begin
						state_d = bsrt_pkg::ST_MRD;
					end else begin
						we      = 1'b1;
						waddr   = i_q[AW-1:0];
						wdata   = '{lo: n_q, hi: rd_q.hi};
						state_d = bsrt_pkg::ST_FRD;
					end
				end else if (cmp.above) begin
					state_d = full ? bsrt_pkg::ST_FRD : bsrt_pkg::ST_INS;
				end else begin
					state_d = bsrt_pkg::ST_WALK;
				end
			end
			bsrt_pkg::ST_MRD: begin
				raddr   = i_dec[AW-1:0];
				state_d = bsrt_pkg::ST_MCHK;
			end
			bsrt_pkg::ST_MCHK: begin
				we = 1'b1;
				if (cmp.above_adj) begin
					waddr   = i_dec[AW-1:0];
					wdata   = '{lo: rd_q.lo, hi: cur_hi_q};
					state_d = bsrt_pkg::ST_REM;
				end else begin
					waddr   = i_q[AW-1:0];
					wdata   = '{lo: n_q, hi: cur_hi_q};
					state_d = bsrt_pkg::ST_FRD;
				end
			end
			bsrt_pkg::ST_INS: begin
				if (k_q == p_q) begin
					we      = 1'b1;
					waddr   = p_q[AW-1:0];
					wdata   = '{lo: n_q, hi: n_q};
					state_d = bsrt_pkg::ST_FRD;
				end else begin
					raddr   = k_dec[AW-1:0];
					state_d = bsrt_pkg::ST_INS_WR;
				end
			end
			bsrt_pkg::ST_INS_WR: begin
				we      = 1'b1;
				waddr   = k_q[AW-1:0];
				wdata   = rd_q;
				state_d = bsrt_pkg::ST_INS;
			end
			bsrt_pkg::ST_REM: begin
				if (k_inc < count_q) begin
					raddr   = k_inc[AW-1:0];
					state_d = bsrt_pkg::ST_REM_WR;
				end else begin
					state_d = bsrt_pkg::ST_FRD;
				end
			end
			bsrt_pkg::ST_REM_WR: begin
				we      = 1'b1;
				waddr   = k_q[AW-1:0];
				wdata   = rd_q;
				state_d = bsrt_pkg::ST_REM;
			end
			bsrt_pkg::ST_FRD: begin
				state_d = bsrt_pkg::ST_FCHK;
			end
			bsrt_pkg::ST_FCHK: begin
				state_d = bsrt_pkg::ST_RES;
			end
			bsrt_pkg::ST_RES: begin
				if (res_take) begin
					state_d = bsrt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bsrt_pkg::ST_IDLE;
			end
		endcase
	end

	// list count and recorded total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			final_q <= '0;
		end else begin
			if (start && (state_q == bsrt_pkg::ST_IDLE) && req.has_number
					&& req.final_marker) begin
				final_q <= req.batch_number;
			end
			if ((state_q == bsrt_pkg::ST_INS) && (k_q == p_q)) begin
				count_q <= count_q + CW'(1);
			end else if ((state_q == bsrt_pkg::ST_REM) && !(k_inc < count_q)) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// walk indexes, working number and result
	always_ff @(posedge clk) begin
		case (state_q)
			bsrt_pkg::ST_IDLE: begin
				n_q   <= req.batch_number;
				i_q   <= count_q;
				ovf_q <= 1'b0;
				res_q <= '{done_res: req.final_marker, contiguous_high: '0, overflow: 1'b0};
			end
			bsrt_pkg::ST_WALK: begin
				if (i_q == '0) begin
					ovf_q <= full;
					p_q   <= '0;
					k_q   <= count_q;
				end else begin
					i_q <= i_dec;
				end
			end
			bsrt_pkg::ST_CHK: begin
				cur_hi_q <= rd_q.hi;
				if (!cmp.covered && !cmp.above_adj && !cmp.below_adj && cmp.above) begin
					ovf_q <= full;
					p_q   <= i_q + CW'(1);
					k_q   <= count_q;
				end
			end
			bsrt_pkg::ST_MCHK: begin
				k_q <= i_q;
			end
			bsrt_pkg::ST_INS_WR: begin
				k_q <= k_dec;
			end
			bsrt_pkg::ST_REM_WR: begin
				k_q <= k_inc;
			end
			bsrt_pkg::ST_FCHK: begin
				res_q <= '{done_res: (final_q != '0) && (final_q == high),
					contiguous_high: high, overflow: ovf_q};
			end
			default: begin
			end
		endcase
	end

	assign stat.idle      = (state_q == bsrt_pkg::ST_IDLE);
	assign stat.res_valid = (state_q == bsrt_pkg::ST_RES);
	assign stat.count     = count_q;
	assign res            = res_q;

endmodule

`default_nettype wire
